[hdl/sasmd_pkg.sv]
// Package: shared types, constants and helpers of the signed add/sub/mul/div unit.
package sasmd_pkg;

	localparam int WORD_W         = 32;
	localparam int CMD_W          = 2;
	localparam int MUL_STEPS      = 32;
	localparam int DATA_WIDTH_DEF = 32;

	typedef enum logic [CMD_W-1:0] {
		CMD_ADD = 2'd0,
		CMD_SUB = 2'd1,
		CMD_MUL = 2'd2,
		CMD_DIV = 2'd3
	} cmd_e_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FIX
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic step;
		logic emit;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;
	} ctrl_sts_t;

	function automatic logic [WORD_W-1:0] negate(input logic [WORD_W-1:0] v);
		negate = ~v + WORD_W'(1);
	endfunction

	function automatic logic [WORD_W-1:0] magnitude(input logic [WORD_W-1:0] v);
		magnitude = v[WORD_W-1] ? negate(v) : v;
	endfunction

endpackage

[hdl/sasmd_in_if.sv]
// Interface: input channel carrying a command and two signed operands.
interface sasmd_in_if;
	logic                                valid;
	logic                                ready;
	logic [sasmd_pkg::CMD_W-1:0]         command;
	logic signed [sasmd_pkg::WORD_W-1:0] operand_a;
	logic signed [sasmd_pkg::WORD_W-1:0] operand_b;

	modport source (output valid, output command, output operand_a, output operand_b,
		input ready);
	modport sink (input valid, input command, input operand_a, input operand_b,
		output ready);
endinterface

[hdl/sasmd_out_if.sv]
// Interface: output channel carrying the result value and remainder.
interface sasmd_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [sasmd_pkg::WORD_W-1:0] value;
	logic signed [sasmd_pkg::WORD_W-1:0] remainder_out;

	modport source (output valid, output value, output remainder_out, input ready);
	modport sink (input valid, input value, input remainder_out, output ready);
endinterface

[hdl/sasmd_ctrl.sv]
// Controller: state machine and step counter that sequence the datapath.
module sasmd_ctrl #(
	parameter int DATA_WIDTH = sasmd_pkg::DATA_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic [sasmd_pkg::CMD_W-1:0] in_command,
	output logic                        in_ready,
	input  sasmd_pkg::ctrl_sts_t        sts,
	output sasmd_pkg::ctrl_cmd_t        cmd
);

	localparam int STEPS_MAX = (DATA_WIDTH > sasmd_pkg::MUL_STEPS) ?
		DATA_WIDTH : sasmd_pkg::MUL_STEPS;
	localparam int CNT_W = $clog2(STEPS_MAX + 1);

	sasmd_pkg::state_t state_q, state_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sasmd_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			sasmd_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					case (in_command)
						sasmd_pkg::CMD_MUL: begin
							cnt_d   = CNT_W'(sasmd_pkg::MUL_STEPS);
							state_d = sasmd_pkg::ST_RUN;
						end
						sasmd_pkg::CMD_DIV: begin
							cnt_d   = CNT_W'(DATA_WIDTH);
							state_d = sasmd_pkg::ST_RUN;
						end
						default: begin
							state_d = sasmd_pkg::ST_FIX;
						end
					endcase
				end
			end
			sasmd_pkg::ST_RUN: begin
				cmd.step = 1'b1;
				cnt_d    = cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					state_d = sasmd_pkg::ST_FIX;
				end
			end
			sasmd_pkg::ST_FIX: begin
				// hold until the output register can take the word
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = sasmd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sasmd_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

[hdl/sasmd_dpath.sv]
// Datapath: operand registers, shift-add / restoring-divide step, sign fix-up, output register.
module sasmd_dpath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [sasmd_pkg::CMD_W-1:0]         in_command,
	input  logic signed [sasmd_pkg::WORD_W-1:0] in_a,
	input  logic signed [sasmd_pkg::WORD_W-1:0] in_b,
	input  sasmd_pkg::ctrl_cmd_t                cmd,
	output sasmd_pkg::ctrl_sts_t                sts,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [sasmd_pkg::WORD_W-1:0] out_value,
	output logic signed [sasmd_pkg::WORD_W-1:0] out_rem
);

	localparam int W = sasmd_pkg::WORD_W;

	logic [sasmd_pkg::CMD_W-1:0] cmd_q;
	logic [W-1:0]                a_q, b_q;
	logic [W:0]                  acc_q;   // product accumulator or partial remainder
	logic [W-1:0]                m_q;     // multiplicand or divisor magnitude
	logic [W-1:0]                n_q;     // multiplier or dividend/quotient shift register
	logic [W-1:0]                value_q, rem_q;
	logic                        out_valid_q;

	logic [W:0]   r_shift;
	logic [W+1:0] r_diff;
	logic [W-1:0] fix_value, fix_rem, sum_ab, diff_ab, res_mag;
	logic         neg_res;

	assign r_shift = {acc_q[W-1:0], n_q[W-1]};
	assign r_diff  = {1'b0, r_shift} - {2'b00, m_q};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= in_command;
			a_q   <= in_a;
			b_q   <= in_b;
			acc_q <= '0;
			if (in_command == sasmd_pkg::CMD_DIV) begin
				m_q <= sasmd_pkg::magnitude(in_b);
				n_q <= sasmd_pkg::magnitude(in_a);
			end else begin
				m_q <= sasmd_pkg::magnitude(in_a);
				n_q <= sasmd_pkg::magnitude(in_b);
			end
		end else if (cmd.step) begin
			if (cmd_q == sasmd_pkg::CMD_DIV) begin
				// restore when the trial subtract goes negative
				if (!r_diff[W+1]) begin
					acc_q <= r_diff[W:0];
					n_q   <= {n_q[W-2:0], 1'b1};
				end else begin
					acc_q <= r_shift;
					n_q   <= {n_q[W-2:0], 1'b0};
				end
			end else begin
				if (n_q[0]) begin
					acc_q <= {1'b0, acc_q[W-1:0] + m_q};
				end
				m_q <= {m_q[W-2:0], 1'b0};
				n_q <= {1'b0, n_q[W-1:1]};
			end
		end
	end

	assign sum_ab  = a_q + b_q;
	assign diff_ab = a_q - b_q;
	assign neg_res = a_q[W-1] ^ b_q[W-1];
	assign res_mag = (cmd_q == sasmd_pkg::CMD_DIV) ? n_q : acc_q[W-1:0];

	always_comb begin
		fix_rem = '0;
		case (cmd_q)
			sasmd_pkg::CMD_ADD: fix_value = sum_ab;
			sasmd_pkg::CMD_SUB: fix_value = diff_ab;
			sasmd_pkg::CMD_MUL: fix_value = neg_res ? sasmd_pkg::negate(res_mag) : res_mag;
			sasmd_pkg::CMD_DIV: begin
				fix_value = neg_res ? sasmd_pkg::negate(res_mag) : res_mag;
				fix_rem   = a_q[W-1] ? sasmd_pkg::negate(acc_q[W-1:0]) : acc_q[W-1:0];
			end
			default: fix_value = sum_ab;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			value_q <= fix_value;
			rem_q   <= fix_rem;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.out_free = !out_valid_q || out_ready;
	assign out_valid    = out_valid_q;
	assign out_value    = value_q;
	assign out_rem      = rem_q;

endmodule

[hdl/signed_add_sub_mul_div_unit.sv]
// Top level: signed add/subtract/multiply/divide unit, controller plus datapath.
//
//  channel   | dir | word contents
//  ----------+-----+-----------------------------------------------
//  operands  | in  | command[1:0], operand_a[31:0], operand_b[31:0]
//  result    | out | value[31:0], remainder_out[31:0]
//
// Add and subtract go from accept straight to the sign fix-up; multiply first runs
// 32 shift-add steps of one adder, then the sign fix-up; divide runs DATA_WIDTH
// restoring steps, one per cycle through one subtractor, then the fix-up. One word is
// in work at a time, so operands are taken only once the last word has left fix-up.
// A result waiting on result.ready holds the unit in its fix-up state; operands
// may be taken meanwhile only after that word has moved to the output register.
// Reset clears the state machine and the output valid flag.
module signed_add_sub_mul_div_unit #(
	parameter int DATA_WIDTH = sasmd_pkg::DATA_WIDTH_DEF
) (
	input logic        clk,
	input logic        arst_n,
	sasmd_in_if.sink   operands,
	sasmd_out_if.source result
);

	sasmd_pkg::ctrl_cmd_t cmd;
	sasmd_pkg::ctrl_sts_t sts;

	sasmd_ctrl #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (operands.valid),
		.in_command (operands.command),
		.in_ready   (operands.ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	sasmd_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_command (operands.command),
		.in_a       (operands.operand_a),
		.in_b       (operands.operand_b),
		.cmd        (cmd),
		.sts        (sts),
		.out_valid  (result.valid),
		.out_ready  (result.ready),
		.out_value  (result.value),
		.out_rem    (result.remainder_out)
	);

endmodule
